### hdl/see_pkg.sv
package see_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned KindW = 3;
  localparam int unsigned StatW = 2;

  typedef enum logic [2:0] {
    KIND_OPERAND = 3'd0,
    KIND_ADD     = 3'd1,
    KIND_SUB     = 3'd2,
    KIND_MUL     = 3'd3,
    KIND_DIV     = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DIV0  = 2'd1,
    ST_UNDER = 2'd2,
    ST_CAP   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_TRD,
    S_TOK,
    S_POP2,
    S_OPER,
    S_MUL2,
    S_DIV,
    S_DIVFIX,
    S_PUSH,
    S_TOPRD,
    S_TOPW,
    S_DONE
  } state_t;

  function automatic logic is_op(input logic [KindW-1:0] k);
    return k inside {KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV};
  endfunction

endpackage

### hdl/see_if.sv
interface see_in_if;
  import see_pkg::*;
  logic valid;
  logic ready;
  logic [KindW-1:0] req_type;
  logic signed [DataW-1:0] operand_value;
  logic last_token;
  modport source (output valid, req_type, operand_value, last_token, input ready);
  modport sink (input valid, req_type, operand_value, last_token, output ready);
endinterface

interface see_out_if;
  import see_pkg::*;
  logic valid;
  logic ready;
  logic signed [DataW-1:0] result_value;
  logic [StatW-1:0] status;
  modport source (output valid, result_value, status, input ready);
  modport sink (input valid, result_value, status, output ready);
endinterface

### hdl/stack_expression_evaluator.sv
// Stack expression evaluator. Tokens are taken one a cycle into a token
// memory; a request with last_token set starts evaluation (postfix if that
// token is an operator, otherwise prefix, read back to front). Evaluation
// runs out of an operand stack memory with registered reads: an operand
// takes token read, decode and push; an add/sub takes token read, decode,
// two pops, operate and push; a multiply adds a partial-product sum step,
// and a divide runs the restoring divider (one quotient bit a cycle, then a
// sign fix). Closing an expression takes top read, capture and result load.
// The 64x64 multiply is built from three 32x32 partial products, registered
// in S_OPER and summed in S_MUL2 (the high-by-high product only affects bits
// above 63). One result per expression, held in an output register until
// taken; the next expression's tokens may load while it waits, and that
// evaluation then holds at its last step until the register frees. New
// tokens are refused while evaluating. Overflow past MAX_TOKENS, stack
// underflow and divide by zero are reported in status with a zero result.
// No clearing pass is needed after reset.
module stack_expression_evaluator import see_pkg::*; #(
  parameter int unsigned MAX_TOKENS = 1024
) (
  input logic clk,
  input logic rst_n,
  see_in_if.sink in_ch,
  see_out_if.source out_ch
);

  localparam int unsigned AW = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
  localparam int unsigned CW = $clog2(MAX_TOKENS + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_TOKENS);

  logic [KindW-1:0] kind_mem [MAX_TOKENS];
  logic [DataW-1:0] val_mem  [MAX_TOKENS];
  logic [DataW-1:0] stk_mem  [MAX_TOKENS];

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;     // tokens stored
  logic [CW-1:0] idx_r, idx_nxt;     // tokens processed
  logic [CW-1:0] sp_r, sp_nxt;
  logic          cap_r, cap_nxt;
  logic          pfx_r, pfx_nxt;     // 1 = postfix
  logic [KindW-1:0] k_r, k_nxt;
  logic [DataW-1:0] a_r, a_nxt;      // a = first popped
  logic [DataW-1:0] res_r, res_nxt;
  logic [DataW-1:0] pp0_r;           // lo x lo
  logic [31:0]      pp1_r, pp2_r;    // cross terms, low halves only
  logic          ov_r, ov_nxt;
  logic [StatW-1:0] os_r, os_nxt;
  logic [StatW-1:0] ost_r, ost_nxt;  // status of the waiting result
  logic [DataW-1:0] ores_r, ores_nxt;
  // divider
  logic [DataW-1:0] dq_r, dq_nxt, dd_r, dd_nxt, drm_r, drm_nxt;
  logic [6:0]       dc_r, dc_nxt;
  logic             dneg_r, dneg_nxt;

  // memory ports
  logic          tok_we, stk_we, tok_re, stk_re;
  logic [AW-1:0] tok_wa, tok_ra, stk_wa, stk_ra;
  logic [DataW-1:0] stk_wd;
  logic [KindW-1:0] kind_q;
  logic [DataW-1:0] val_q, stk_q;

  always_ff @(posedge clk) begin
    if (tok_we) begin
      kind_mem[tok_wa] <= in_ch.req_type;
      val_mem[tok_wa]  <= in_ch.operand_value;
    end
    if (tok_re) begin
      kind_q <= kind_mem[tok_ra];
      val_q  <= val_mem[tok_ra];
    end
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (stk_re) stk_q <= stk_mem[stk_ra];
  end

  wire acc_in  = in_ch.valid && in_ch.ready;
  wire acc_out = out_ch.valid && out_ch.ready;

  assign in_ch.ready        = (state_r == S_LOAD);
  assign out_ch.valid       = ov_r;
  assign out_ch.result_value = ores_r;
  assign out_ch.status      = ost_r;

  // next-state logic
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD:   if (acc_in && in_ch.last_token) begin
                  state_nxt = (cap_r || cnt_r == MaxCnt) ? S_DONE : S_TRD;
                end
      S_TRD:    state_nxt = S_TOK;
      S_TOK:    state_nxt = is_op(kind_q) ? ((sp_r < CW'(2)) ? S_DONE : S_POP2)
                                         : ((sp_r < MaxCnt) ? S_PUSH
                                            : ((idx_r == cnt_r) ? S_TOPRD : S_TRD));
      S_POP2:   state_nxt = S_OPER;
      S_OPER:   state_nxt = (k_r == KIND_MUL) ? S_MUL2
                          : (k_r == KIND_DIV) ? ((((pfx_r ? a_r : stk_q)) == '0) ? S_DONE
                                                : S_DIV)
                          : S_PUSH;
      S_MUL2:   state_nxt = S_PUSH;
      S_DIV:    if (dc_r == 7'd63) state_nxt = S_DIVFIX;
      S_DIVFIX: state_nxt = S_PUSH;
      S_PUSH:   state_nxt = (idx_r == cnt_r) ? S_TOPRD : S_TRD;
      S_TOPRD:  state_nxt = S_TOPW;
      S_TOPW:   state_nxt = S_DONE;
      // wait here while the previous result is still unclaimed
      S_DONE:   state_nxt = (ov_r && !out_ch.ready) ? S_DONE : S_LOAD;
      default:  state_nxt = S_LOAD;
    endcase
  end

  // datapath / outputs
  logic [DataW-1:0] l_op, r_op, ml, mr, rem_sh;
  logic [DataW:0]   trial;
  always_comb begin
    cnt_nxt = cnt_r; idx_nxt = idx_r; sp_nxt = sp_r; cap_nxt = cap_r;
    pfx_nxt = pfx_r; k_nxt = k_r; a_nxt = a_r; res_nxt = res_r;
    ov_nxt = ov_r; os_nxt = os_r; ost_nxt = ost_r; ores_nxt = ores_r;
    dq_nxt = dq_r; dd_nxt = dd_r; drm_nxt = drm_r; dc_nxt = dc_r; dneg_nxt = dneg_r;
    tok_we = 1'b0; tok_wa = cnt_r[AW-1:0];
    tok_re = 1'b0; tok_ra = '0;
    stk_we = 1'b0; stk_wa = '0; stk_wd = res_r;
    stk_re = 1'b0; stk_ra = '0;
    l_op = pfx_r ? stk_q : a_r;
    r_op = pfx_r ? a_r : stk_q;
    ml = l_op[DataW-1] ? (~l_op + 1'b1) : l_op;
    mr = r_op[DataW-1] ? (~r_op + 1'b1) : r_op;
    rem_sh = {drm_r[DataW-2:0], dq_r[DataW-1]};
    trial = {1'b0, rem_sh} - {1'b0, dd_r};
    if (acc_out) ov_nxt = 1'b0;
    case (state_r)
      S_LOAD: if (acc_in) begin
        if (cnt_r < MaxCnt) begin
          tok_we = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          cap_nxt = 1'b1;
        end
        if (in_ch.last_token) begin
          // final kind: the one just stored, or unstored if full
          pfx_nxt = is_op(in_ch.req_type);
          idx_nxt = '0;
          sp_nxt = '0;
          os_nxt = ST_CAP;
          res_nxt = '0;
        end
      end
      S_TRD: begin
        tok_re = 1'b1;
        tok_ra = pfx_r ? idx_r[AW-1:0] : AW'(cnt_r - 1'b1 - idx_r);
        idx_nxt = idx_r + 1'b1;
        os_nxt = ST_OK;
      end
      S_TOK: begin
        k_nxt = kind_q;
        res_nxt = val_q;
        if (is_op(kind_q)) begin
          if (sp_r < CW'(2)) begin
            os_nxt = ST_UNDER;
            res_nxt = '0;
          end else begin
            stk_re = 1'b1;
            stk_ra = AW'(sp_r - 1'b1);
            sp_nxt = sp_r - CW'(2);
          end
        end
      end
      S_POP2: begin
        a_nxt = stk_q;
        stk_re = 1'b1;
        stk_ra = sp_r[AW-1:0];
      end
      S_OPER: begin
        case (k_r)
          KIND_ADD: res_nxt = l_op + r_op;
          KIND_SUB: res_nxt = l_op - r_op;
          KIND_MUL: ;  // partial products register this cycle
          default: begin
            if (r_op == '0) begin
              os_nxt = ST_DIV0;
              res_nxt = '0;
            end else begin
              dq_nxt = ml; dd_nxt = mr; drm_nxt = '0; dc_nxt = '0;
              dneg_nxt = l_op[DataW-1] ^ r_op[DataW-1];
            end
          end
        endcase
      end
      S_MUL2: res_nxt = pp0_r + {pp1_r + pp2_r, 32'd0};
      S_DIV: begin
        dc_nxt = dc_r + 1'b1;
        if (!trial[DataW]) begin
          drm_nxt = trial[DataW-1:0];
          dq_nxt = {dq_r[DataW-2:0], 1'b1};
        end else begin
          drm_nxt = rem_sh;
          dq_nxt = {dq_r[DataW-2:0], 1'b0};
        end
      end
      S_DIVFIX: res_nxt = dneg_r ? (~dq_r + 1'b1) : dq_r;
      S_PUSH: begin
        if (sp_r < MaxCnt) begin
          stk_we = 1'b1;
          stk_wa = sp_r[AW-1:0];
          stk_wd = res_r;
          sp_nxt = sp_r + 1'b1;
        end
      end
      S_TOPRD: begin
        stk_re = 1'b1;
        stk_ra = AW'(sp_r - 1'b1);
        if (sp_r == '0) os_nxt = ST_UNDER;
      end
      S_TOPW: res_nxt = (os_r == ST_OK) ? stk_q : '0;
      S_DONE: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt = 1'b1;
          ores_nxt = (os_r == ST_OK) ? res_r : '0;
          ost_nxt = os_r;
          cnt_nxt = '0;
          cap_nxt = 1'b0;
          sp_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  // operands are final in S_OPER; the sum is taken in S_MUL2
  always_ff @(posedge clk) begin
    pp0_r <= DataW'(l_op[31:0]) * DataW'(r_op[31:0]);
    pp1_r <= l_op[63:32] * r_op[31:0];
    pp2_r <= l_op[31:0] * r_op[63:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r <= '0; idx_r <= '0; sp_r <= '0; cap_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt; idx_r <= idx_nxt; sp_r <= sp_nxt; cap_r <= cap_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pfx_r <= pfx_nxt; k_r <= k_nxt; a_r <= a_nxt; res_r <= res_nxt;
    os_r <= os_nxt; ost_r <= ost_nxt; ores_r <= ores_nxt;
    dq_r <= dq_nxt; dd_r <= dd_nxt; drm_r <= drm_nxt; dc_r <= dc_nxt;
    dneg_r <= dneg_nxt;
  end

  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD) |-> !in_ch.ready) else $error("ready while busy");
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= MaxCnt) else $error("stack pointer out of range");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MaxCnt) else $error("token count out of range");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ch.ready) |=> ov_r) else $error("result dropped");

endmodule

### tb/sv/stack_expression_evaluator_tb.sv
module stack_expression_evaluator_tb;
  import see_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxTok = 1024;
  localparam logic [63:0] MinVal = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MaxVal = 64'h7fff_ffff_ffff_ffff;

  typedef struct {
    logic [KindW-1:0] kind;
    logic [DataW-1:0] val;
  } token_t;

  typedef struct {
    logic [DataW-1:0] value;
    logic [StatW-1:0] status;
  } answer_t;

  logic clk;
  logic rst_n;

  see_in_if in_ch ();
  see_out_if out_ch ();

  stack_expression_evaluator #(.MAX_TOKENS(MaxTok)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  // Predictor state: the tokens of the expression in flight and the sticky
  // capacity flag.
  token_t  expr_buf[$];
  bit      cap_hit;
  answer_t pending_answers[$];

  int mismatches;
  bit no_idle;       // long stretch with both sides always active
  bit hold_req;      // asks the receiver for one long hold-off

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic bit kind_is_op(logic [KindW-1:0] k);
    return k inside {KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV};
  endfunction

  // Signed divide truncating toward zero; most-negative / -1 wraps.
  function automatic logic [63:0] trunc_div(logic [63:0] l, logic [63:0] r);
    logic [63:0] ml, mr, q;
    ml = l[63] ? -l : l;
    mr = r[63] ? -r : r;
    q = ml / mr;
    return (l[63] != r[63]) ? -q : q;
  endfunction

  // Evaluates the buffered expression; postfix when the final token is an
  // operator, else prefix read back to front with the first pop as left.
  function automatic answer_t evaluate_expr();
    answer_t a;
    logic [63:0] stk[$];
    logic [63:0] first, second, l, r, res;
    bit postfix;
    int n, idx;
    token_t t;
    a.value = '0;
    a.status = ST_OK;
    n = expr_buf.size();
    postfix = kind_is_op(expr_buf[n-1].kind);
    for (int i = 0; i < n && a.status == ST_OK; i++) begin
      idx = postfix ? i : n - 1 - i;
      t = expr_buf[idx];
      if (!kind_is_op(t.kind)) begin
        stk.push_back(t.val);
      end else if (stk.size() < 2) begin
        a.status = ST_UNDER;
      end else begin
        first = stk.pop_back();
        second = stk.pop_back();
        l = postfix ? second : first;
        r = postfix ? first : second;
        case (t.kind)
          KIND_ADD: res = l + r;
          KIND_SUB: res = l - r;
          KIND_MUL: res = l * r;
          default: begin
            if (r == 0) a.status = ST_DIV0;
            else res = trunc_div(l, r);
          end
        endcase
        if (a.status == ST_OK) stk.push_back(res);
      end
    end
    if (a.status == ST_OK) begin
      if (stk.size() == 0) a.status = ST_UNDER;
      else a.value = stk[$];
    end
    if (a.status != ST_OK) a.value = '0;
    return a;
  endfunction

  // Predictor update for one accepted request.
  task automatic absorb_token(logic [KindW-1:0] k, logic [63:0] v, logic last);
    token_t t;
    answer_t a;
    t.kind = k;
    t.val = v;
    if (expr_buf.size() < MaxTok) expr_buf.push_back(t);
    else cap_hit = 1'b1;
    if (last) begin
      if (cap_hit) begin
        a.value = '0;
        a.status = ST_CAP;
      end else begin
        a = evaluate_expr();
      end
      pending_answers.push_back(a);
      expr_buf.delete();
      cap_hit = 1'b0;
    end
  endtask

  // Drives one request, called at a falling edge; returns at a falling edge
  // with valid still high so back-to-back requests need no re-raise.
  task automatic send_token(logic [KindW-1:0] k, logic [63:0] v, logic last);
    while (!no_idle && $urandom_range(99) < 23) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.req_type = k;
    in_ch.operand_value = v;
    in_ch.last_token = last;
    do @(posedge clk); while (!in_ch.ready);
    absorb_token(k, v, last);
    @(negedge clk);
  endtask

  task automatic send_list(token_t toks[$]);
    foreach (toks[i]) send_token(toks[i].kind, toks[i].val, i == toks.size() - 1);
  endtask

  task automatic drain();
    int guard;
    in_ch.valid = 1'b0;
    guard = 0;
    while (pending_answers.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (100) @(negedge clk);
  endtask

  function automatic token_t mk(logic [KindW-1:0] k, logic [63:0] v);
    token_t t;
    t.kind = k;
    t.val = v;
    return t;
  endfunction

  function automatic logic [63:0] rand_val();
    case ($urandom_range(9))
      0: return '0;
      1: return 64'd1;
      2: return '1;
      3: return MinVal;
      4: return MaxVal;
      5: return 64'($urandom_range(20));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Well-formed postfix over n_opnd operands with random operators.
  function automatic void gen_postfix(int n_opnd, ref token_t toks[$]);
    int depth, left;
    depth = 0;
    left = n_opnd;
    toks.delete();
    while (left > 0 || depth > 1) begin
      if (left > 0 && (depth < 2 || $urandom_range(1))) begin
        toks.push_back(mk(KIND_OPERAND, rand_val()));
        depth++;
        left--;
      end else begin
        toks.push_back(mk(kind_t'($urandom_range(KIND_DIV, KIND_ADD)), {$urandom, $urandom}));
        depth--;
      end
    end
  endfunction

  // ---------------------------------------------------------------- receiver
  // Ready idles at random; one long hold-off when asked, so the result
  // register fills and the input side backs up.
  initial begin
    int hold_cycles;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready = 1'b0;
        for (hold_cycles = 0; hold_cycles < 400; hold_cycles++) @(negedge clk);
      end
      out_ch.ready = no_idle || ($urandom_range(99) >= 23);
    end
  end

  // ----------------------------------------------------------------- checker
  always @(posedge clk) begin
    answer_t exp_a;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result value=%h status=%0d", out_ch.result_value,
                   out_ch.status);
      end else begin
        exp_a = pending_answers.pop_front();
        if (out_ch.result_value !== exp_a.value || out_ch.status !== exp_a.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                     exp_a.value, exp_a.status, out_ch.result_value, out_ch.status);
        end
      end
    end
  end

  // ------------------------------------------------------------ test tasks
  // Basic arithmetic both ways, wrap on multiply, division signs.
  task automatic test_arith();
    token_t q[$];
    q = '{mk(KIND_OPERAND, 3), mk(KIND_OPERAND, 4), mk(KIND_ADD, 0)};
    send_list(q);
    q = '{mk(KIND_SUB, 0), mk(KIND_OPERAND, 10), mk(KIND_OPERAND, 3)};
    send_list(q);
    q = '{mk(KIND_OPERAND, MaxVal), mk(KIND_OPERAND, MaxVal), mk(KIND_MUL, '1)};
    send_list(q);
    q = '{mk(KIND_OPERAND, -64'sd7), mk(KIND_OPERAND, 2), mk(KIND_DIV, 0)};
    send_list(q);
    q = '{mk(KIND_DIV, 0), mk(KIND_OPERAND, 7), mk(KIND_OPERAND, -64'sd2)};
    send_list(q);
    q = '{mk(KIND_OPERAND, MinVal), mk(KIND_OPERAND, MinVal), mk(KIND_ADD, 0)};
    send_list(q);
  endtask

  // Most negative over -1, divide by zero, underflow, leftovers, odd kinds.
  task automatic test_special();
    token_t q[$];
    q = '{mk(KIND_OPERAND, MinVal), mk(KIND_OPERAND, '1), mk(KIND_DIV, 0)};
    send_list(q);
    q = '{mk(KIND_OPERAND, 5), mk(KIND_OPERAND, 0), mk(KIND_DIV, 0)};
    send_list(q);
    q = '{mk(KIND_ADD, 0)};
    send_list(q);
    q = '{mk(KIND_OPERAND, 1), mk(KIND_MUL, 0)};
    send_list(q);
    q = '{mk(KIND_OPERAND, 11), mk(KIND_OPERAND, 22)};
    send_list(q);
    q = '{mk(3'd5, 64'd9), mk(3'd6, MaxVal), mk(KIND_SUB, 0)};
    send_list(q);
    q = '{mk(3'd7, MinVal)};
    send_list(q);
  endtask

  // Buffer filled exactly, then the final request arrives past the end.
  task automatic test_capacity();
    for (int i = 0; i < MaxTok + 1; i++)
      send_token(KIND_OPERAND, 64'(i), i == MaxTok);
  endtask

  // Long receiver hold-off while the sender keeps offering requests.
  task automatic test_backpressure();
    token_t q[$];
    hold_req = 1'b1;
    for (int e = 0; e < 12; e++) begin
      gen_postfix(2, q);
      send_list(q);
    end
  endtask

  // Mostly well-formed expressions, small sizes, plus some random noise.
  task automatic test_random(int n_items);
    token_t q[$];
    int sent, sel;
    sent = 0;
    while (sent < n_items) begin
      if (sent > n_items / 3 && sent < n_items / 2) no_idle = 1'b1;
      else no_idle = 1'b0;
      sel = $urandom_range(9);
      gen_postfix($urandom_range(6, 1), q);
      if (sel < 4) begin
        q.reverse();
      end else if (sel == 9) begin
        q.delete();
        repeat ($urandom_range(6, 1)) q.push_back(mk(3'($urandom_range(7)), rand_val()));
      end
      send_list(q);
      sent += q.size();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    mismatches = 0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    cap_hit = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = KIND_OPERAND;
    in_ch.operand_value = '0;
    in_ch.last_token = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_arith();
    test_special();
    drain();
    test_capacity();
    drain();
    test_backpressure();
    drain();
    test_random(950);
    drain();
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
